// ----- src/rational_arith_unit_defines.svh -----
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rau_pkg.sv -----
// ------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

   localparam int OperandWidth = 32;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int CntWidth     = $clog2(ProdWidth + 1);

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] num_a;
      logic [31:0] den_a;
      logic [31:0] num_b;
      logic [31:0] den_b;
   } req_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0]  status;
   } rsp_type;

   // Classified operation passed from front to back
   typedef struct packed {
      logic                  zero_den;
      logic [1:0]            func;
      logic                  na_neg;
      logic [OperandWidth:0] na_mag;
      logic                  da_neg;
      logic [OperandWidth:0] da_mag;
      logic                  nb_neg;
      logic [OperandWidth:0] nb_mag;
      logic                  db_neg;
      logic [OperandWidth:0] db_mag;
   } job_type;

   // Control handshake between queue and back end
   typedef struct packed {
      logic valid;
      logic take;
   } qctl_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_EMIT
   } back_state_type;

endpackage

// ----- src/rau_front.sv -----
// ------------------------------------------------------------------
// rau_front
// Accepts an item, converts operands to sign/magnitude and flags a
// zero denominator.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_front (
   input  rau_pkg::req_type req,
   output rau_pkg::job_type job
);
   import rau_pkg::*;

   logic [OperandWidth-1:0] na_w, da_w, nb_w, db_w;

   function automatic logic [OperandWidth:0] mag_of(input logic [OperandWidth-1:0] v);
      logic [OperandWidth:0] ext;
      ext = {1'b0, v};
      return v[OperandWidth-1] ? ((OperandWidth+1)'(1) << OperandWidth) - ext : ext;
   endfunction

   // Operand slices at the configured width
   assign na_w = req.num_a[OperandWidth-1:0];
   assign da_w = req.den_a[OperandWidth-1:0];
   assign nb_w = req.num_b[OperandWidth-1:0];
   assign db_w = req.den_b[OperandWidth-1:0];

   // Classification
   always_comb begin
      job.func   = req.func;
      job.na_neg = na_w[OperandWidth-1];
      job.da_neg = da_w[OperandWidth-1];
      job.nb_neg = nb_w[OperandWidth-1];
      job.db_neg = db_w[OperandWidth-1];
      job.na_mag = mag_of(na_w);
      job.da_mag = mag_of(da_w);
      job.nb_mag = mag_of(nb_w);
      job.db_mag = mag_of(db_w);
      job.zero_den = (da_w == '0) || (db_w == '0) ||
                     ((req.func == FUNC_DIV) && (nb_w == '0));
   end

endmodule

// ----- src/rau_queue.sv -----
// ------------------------------------------------------------------
// rau_queue
// Two-entry queue holding classified items between front and back.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rau_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output rau_pkg::qctl_type ctl,
   output rau_pkg::job_type head
);
   import rau_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign ctl.valid = (cnt_ff != 2'd0);
   assign ctl.take  = pop;
   assign head      = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// ----- src/rau_divider.sv -----
// ------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle over the product width.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [rau_pkg::ProdWidth-1:0] dividend,
   input  logic [rau_pkg::ProdWidth-1:0] divisor,
   output logic                           done,
   output logic [rau_pkg::ProdWidth-1:0] quot,
   output logic [rau_pkg::ProdWidth-1:0] rem
);
   import rau_pkg::*;

   logic [ProdWidth-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [ProdWidth:0]   trial;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   assign quot = q_ff;
   assign rem  = r_ff;
   assign done = done_ff;
   assign trial = {r_ff, q_ff[ProdWidth-1]} - {1'b0, d_ff};

   // One shift-subtract step per cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (go) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CntWidth'(ProdWidth); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[ProdWidth]) begin
            r_in = trial[ProdWidth-1:0];
            q_in = {q_ff[ProdWidth-2:0], 1'b1};
         end else begin
            r_in = {r_ff[ProdWidth-2:0], q_ff[ProdWidth-1]};
            q_in = {q_ff[ProdWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

endmodule

// ----- src/rau_back.sv -----
// ------------------------------------------------------------------
// rau_back
// Forms cross products, reduces by Euclidean GCD, normalizes sign and
// checks range.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_back (
   input  logic              clock,
   input  logic              reset,
   input  rau_pkg::qctl_type qin,
   input  rau_pkg::job_type  job,
   output logic              pop,
   output logic              idle,
   output logic              rsp_strobe,
   output rau_pkg::rsp_type  rsp
);
   import rau_pkg::*;

   localparam int W = OperandWidth;
   localparam int P = ProdWidth;

   back_state_type state_ff, state_in;
   job_type              job_ff;
   logic [P-1:0]         p0_ff, p1_ff, pd_ff, p0_in, p1_in, pd_in;
   logic                 s0_ff, s1_ff, sd_ff, s0_in, s1_in, sd_in;
   logic [P-1:0]         a_ff, b_ff, a_in, b_in;
   logic [P-1:0]         n_ff, d_ff, n_in, d_in;
   logic                 nneg_ff, nneg_in;
   logic [P-1:0]         nq_ff, nq_in;
   logic [W:0]           ma, mb;
   logic [2*W+1:0]       prod;
   logic                 x_neg;
   logic [P-1:0]         sum_mag;
   logic                 sum_neg;
   logic                 div_go;
   logic [P-1:0]         div_a, div_b, quot, rem;
   logic                 div_done;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;
   logic [P-1:0]         limit;

   assign limit = P'(1) << (W - 1);

   rau_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quot(quot), .rem(rem)
   );

   // Shared multiplier operand selection
   always_comb begin
      ma = job_ff.na_mag; mb = job_ff.db_mag;
      case (state_ff)
         S_MUL1: begin
            ma = job_ff.na_mag;
            mb = (job_ff.func == FUNC_MUL) ? job_ff.nb_mag : job_ff.db_mag;
         end
         S_MUL2: begin
            ma = job_ff.da_mag;
            mb = job_ff.nb_mag;
         end
         default: begin
            ma = job_ff.na_mag;
            mb = job_ff.db_mag;
         end
      endcase
   end
   assign prod = ma * mb;

   // Signed sum of the two cross products
   always_comb begin
      if (s0_ff == s1_ff) begin
         sum_mag = p0_ff + p1_ff; sum_neg = s0_ff;
      end else if (p0_ff >= p1_ff) begin
         sum_mag = p0_ff - p1_ff; sum_neg = s0_ff;
      end else begin
         sum_mag = p1_ff - p0_ff; sum_neg = s1_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (qin.valid) state_in = job.zero_den ? S_EMIT : S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_SUM;
         S_SUM:   state_in = (n_in == '0) ? S_EMIT : S_GCD;
         S_GCD:   if (div_done && rem == '0) state_in = S_DIVN;
         S_DIVN:  if (div_done) state_in = S_DIVD;
         S_DIVD:  if (div_done) state_in = S_CHECK;
         S_CHECK: state_in = S_EMIT;
         S_EMIT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      p0_in = p0_ff; p1_in = p1_ff; pd_in = pd_ff;
      s0_in = s0_ff; s1_in = s1_ff; sd_in = sd_ff;
      a_in = a_ff; b_in = b_ff; n_in = n_ff; d_in = d_ff;
      nneg_in = nneg_ff; nq_in = nq_ff;
      rsp_in = rsp_ff; strobe_in = 1'b0;
      pop = 1'b0; div_go = 1'b0; div_a = a_ff; div_b = b_ff;
      x_neg = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pop = qin.valid;
            if (qin.valid && job.zero_den) begin
               rsp_in = '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
            end
         end
         S_MUL1: begin
            // na*db for add/sub/div; na*nb for multiply
            x_neg = (job_ff.func == FUNC_MUL) ? (job_ff.na_neg ^ job_ff.nb_neg)
                                              : (job_ff.na_neg ^ job_ff.db_neg);
            p0_in = prod[P-1:0];
            s0_in = (prod != '0) && x_neg;
            // note: operand select above used na,nb for multiply
         end
         S_MUL2: begin
            // da*nb (cross) then denominator
            x_neg = job_ff.da_neg ^ (job_ff.nb_neg ^ (job_ff.func == FUNC_SUB));
            p1_in = prod[P-1:0];
            s1_in = (prod != '0) && x_neg;
            if (job_ff.func == FUNC_DIV) begin
               pd_in = prod[P-1:0];
               sd_in = (prod != '0) && (job_ff.da_neg ^ job_ff.nb_neg);
            end
         end
         S_SUM: begin
            if (job_ff.func == FUNC_MUL || job_ff.func == FUNC_DIV) begin
               n_in = p0_ff; nneg_in = s0_ff;
            end else begin
               n_in = sum_mag; nneg_in = sum_neg;
            end
            if (job_ff.func != FUNC_DIV) begin
               d_in = pd_ff;
               nneg_in = nneg_in ^ sd_ff;
            end else begin
               d_in = pd_ff;
               nneg_in = nneg_in ^ sd_ff;
            end
            a_in = n_in; b_in = d_in;
            div_go = (n_in != '0);
            div_a = n_in; div_b = d_in;
            if (n_in == '0) begin
               rsp_in = '{res_num: '0, res_den: 31'd1, status: ST_OK};
            end
         end
         S_GCD: begin
            if (div_done) begin
               if (rem == '0) begin
                  div_go = 1'b1; div_a = n_ff; div_b = b_ff;
               end else begin
                  a_in = b_ff; b_in = rem;
                  div_go = 1'b1; div_a = b_ff; div_b = rem;
               end
            end
         end
         S_DIVN: begin
            if (div_done) begin
               nq_in = quot;
               div_go = 1'b1; div_a = d_ff; div_b = b_ff;
            end
         end
         S_DIVD: begin
            if (div_done) d_in = quot;
         end
         S_CHECK: begin
            if (d_ff > limit - 1'b1 ||
                (nneg_ff ? (nq_ff > limit) : (nq_ff > limit - 1'b1))) begin
               rsp_in = '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
            end else begin
               rsp_in.res_num = 32'(nneg_ff ? (P'(0) - nq_ff) : nq_ff);
               rsp_in.res_den = d_ff[30:0];
               rsp_in.status  = ST_OK;
            end
         end
         S_EMIT: strobe_in = 1'b1;
         default: ;
      endcase
   end

   // Denominator product computed during MUL1 for non-divide ops
   // uses da*db; captured separately below
   logic [2*W+1:0] dprod;
   assign dprod = job_ff.da_mag * job_ff.db_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && qin.valid) job_ff <= job;
      p0_ff <= p0_in; p1_ff <= p1_in; s0_ff <= s0_in; s1_ff <= s1_in;
      if (state_ff == S_MUL1 && job_ff.func != FUNC_DIV) begin
         pd_ff <= dprod[P-1:0];
         sd_ff <= job_ff.da_neg ^ job_ff.db_neg;
      end else begin
         pd_ff <= pd_in;
         sd_ff <= sd_in;
      end
      a_ff <= a_in; b_ff <= b_in; n_ff <= n_in; d_ff <= d_in;
      nneg_ff <= nneg_in; nq_ff <= nq_in; rsp_ff <= rsp_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- src/rational_arith_unit.sv -----
// ------------------------------------------------------------------
// rational_arith_unit
// Signed fraction add/sub/mul/div with GCD reduction.
// ------------------------------------------------------------------
// channel | ports                       | handshake
// input   | start, busy, req            | start && !busy
// result  | rsp_strobe, rsp             | strobe, one cycle, no stall
// Steps: an accepted item waits in the queue, then runs MUL1, MUL2 and
// SUM, Euclid steps in GCD, DIVN and DIVD on the shared 64-bit restoring
// divider, then CHECK and EMIT; the back end takes one item at a time.
// A zero denominator goes straight from IDLE to EMIT, a zero numerator from SUM.
// busy is high while the two-entry queue is full. Reset clears queue and
// state machines. The receiver cannot stall.
// ------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arith_unit_defines.svh"

module rational_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req,
   output logic             rsp_strobe,
   output rau_pkg::rsp_type rsp
);
   import rau_pkg::*;

   job_type  fjob, head;
   qctl_type qctl;
   logic     full, pop, idle, push;

   assign busy = full;
   assign push = start && !busy;

   rau_front u_front (.req(req), .job(fjob));

   rau_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(fjob),
      .full(full), .pop(pop), .ctl(qctl), .head(head)
   );

   rau_back u_back (
      .clock(clock), .reset(reset), .qin(qctl), .job(head), .pop(pop),
      .idle(idle), .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

   `RAU_ASSERT_IMP(a_pop_valid, clock, reset, pop, qctl.valid, "pop from empty queue")
   `RAU_ASSERT_IMP(a_pop_idle, clock, reset, pop, idle, "pop while back end busy")
   `RAU_ASSERT_NEXT(a_strobe_one, clock, reset, rsp_strobe, !rsp_strobe, "strobe held")
   `RAU_ASSERT_IMP(a_den_ok, clock, reset, rsp_strobe && rsp.status == ST_OK,
      rsp.res_den != '0, "ok result with zero denominator")

endmodule

// ----- tb/sv/rational_arith_unit_test.sv -----
// ------------------------------------------------------------------
// rational_arith_unit_test
// Self-checking bench for the rational arithmetic unit: drives directed
// and random fraction items with random gaps, predicts each reduced
// result in the bench, and compares every strobed result in order.
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arith_unit_test;
   import rau_pkg::*;

   localparam int Width     = 32;
   localparam int NumRandom = 830;
   localparam int CycleMax  = 25000000;

   // Predicts reduced fractions and checks results in arrival order
   class fraction_scoreboard;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // signed operand to sign and magnitude
      static function void split(input logic [31:0] raw, output bit neg,
                                 output logic [63:0] mag);
         neg = raw[Width-1];
         mag = neg ? (64'd1 << Width) - {32'd0, raw} : {32'd0, raw};
      endfunction

      static function logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // sign-magnitude sum
      static function void smsum(input bit xn, input logic [63:0] xm, input bit yn,
                                 input logic [63:0] ym, output bit rn,
                                 output logic [63:0] rm);
         if (xn == yn) begin
            rm = xm + ym;
            rn = xn;
         end else if (xm >= ym) begin
            rm = xm - ym;
            rn = xn;
         end else begin
            rm = ym - xm;
            rn = yn;
         end
         if (rm == 0) rn = 0;
      endfunction

      function void note_item(input req_type r);
         bit          nan, dan, nbn, dbn, nn, dn, pn, qn, neg;
         logic [63:0] nam, dam, nbm, dbm, nm, dm, pm, qm, g, lim;
         rsp_type     e;
         split(r.num_a, nan, nam);
         split(r.den_a, dan, dam);
         split(r.num_b, nbn, nbm);
         split(r.den_b, dbn, dbm);
         e = '0;
         if (dam == 0 || dbm == 0 || (func_type'(r.func) == FUNC_DIV && nbm == 0)) begin
            e.status = ST_ZERO_DEN;
            pending = {pending, e};
            return;
         end
         if (func_type'(r.func) == FUNC_SUB) nbn = !nbn;
         case (func_type'(r.func))
            FUNC_ADD, FUNC_SUB: begin
               pm = nam * dbm;
               pn = (pm != 0) && (nan != dbn);
               qm = dam * nbm;
               qn = (qm != 0) && (dan != nbn);
               smsum(pn, pm, qn, qm, nn, nm);
               dm = dam * dbm;
               dn = dan != dbn;
            end
            FUNC_MUL: begin
               nm = nam * nbm;
               nn = (nm != 0) && (nan != nbn);
               dm = dam * dbm;
               dn = dan != dbn;
            end
            default: begin
               nm = nam * dbm;
               nn = (nm != 0) && (nan != dbn);
               dm = dam * nbm;
               dn = dan != nbn;
            end
         endcase
         if (nm == 0) begin
            e.res_den = 31'd1;
            e.status  = ST_OK;
         end else begin
            g   = euclid(nm, dm);
            nm  = nm / g;
            dm  = dm / g;
            neg = nn != dn;
            lim = 64'd1 << (Width - 1);
            if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
               e.status = ST_OVERFLOW;
            end else begin
               e.res_num = neg ? 32'(-nm) : nm[31:0];
               e.res_den = dm[30:0];
               e.status  = ST_OK;
            end
         end
         pending = {pending, e};
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.res_num !== e.res_num) begin
            $error("res_num expected %0d actual %0d", $signed(e.res_num),
                   $signed(got.res_num));
            errors++;
         end
         if (got.res_den !== e.res_den) begin
            $error("res_den expected %0d actual %0d", e.res_den, got.res_den);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;
   int      cycle_count;

   fraction_scoreboard board;

   rational_arith_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // results and timeout, sampled at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) board.check_result(rsp);
      if (cycle_count > CycleMax) begin
         $display("rational_arith_unit_test: done, errors");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, some stretches with none
   function automatic int gap_len();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: n = 0;
         9:          n = $urandom_range(20, 400);
         default:    n = $urandom_range(1, 6);
      endcase
      return n;
   endfunction

   // present one item and hold it until accepted; called at a falling edge
   task automatic send_item(input req_type r);
      int n;
      n = gap_len();
      if (n != 0) begin
         start <= 1'b0;
         req   <= '0;
         repeat (n) @(negedge clock);
      end
      req   <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(r);
      @(negedge clock);
   endtask

   function automatic req_type make_item(input logic [1:0] f, input logic [31:0] na,
                                         input logic [31:0] da, input logic [31:0] nb,
                                         input logic [31:0] db);
      req_type r;
      r.func  = f;
      r.num_a = na;
      r.den_a = da;
      r.num_b = nb;
      r.den_b = db;
      return r;
   endfunction

   // operand mix: small values give reachable reductions, wide ones stress bits
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff} ^
                         ($urandom_range(0, 1) ? 32'h0 : 32'hffffffff);
         2:       return 32'h80000000;
         3:       return 32'(-$urandom_range(1, 1000));
         4:       return 32'($urandom_range(0, 70000));
         default: return 32'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   function automatic logic [31:0] pick_den();
      logic [31:0] v;
      v = pick_value();
      if (v == 0 && $urandom_range(0, 7) != 0) v = 32'd1;
      return v;
   endfunction

   initial begin
      func_type f;
      board       = new();
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every operation, zero denominators, zero numerator, extremes
      send_item(make_item(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
      send_item(make_item(FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2));
      send_item(make_item(FUNC_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9));
      send_item(make_item(FUNC_DIV, 32'd7, 32'd1, 32'd3, 32'd1));
      send_item(make_item(FUNC_DIV, 32'd3, 32'd1, 32'd7, 32'd5));
      send_item(make_item(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1));
      send_item(make_item(FUNC_MUL, 32'd1, 32'd1, 32'd1, 32'd0));
      send_item(make_item(FUNC_DIV, 32'd1, 32'd1, 32'd0, 32'd5));
      send_item(make_item(FUNC_MUL, 32'd0, 32'd5, 32'd9, 32'd7));
      send_item(make_item(FUNC_ADD, 32'h80000000, 32'd1, 32'd0, 32'd1));
      send_item(make_item(FUNC_SUB, 32'h80000000, 32'd1, 32'd0, 32'd1));
      send_item(make_item(FUNC_MUL, 32'h80000000, 32'h80000000, 32'd1, 32'd1));
      send_item(make_item(FUNC_MUL, 32'h7fffffff, 32'd1, 32'd2, 32'd1));
      send_item(make_item(FUNC_DIV, 32'h80000000, 32'd1, 32'hffffffff, 32'd1));
      send_item(make_item(FUNC_ADD, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                          32'h80000000));
      send_item(make_item(FUNC_DIV, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff));
      send_item(make_item(FUNC_MUL, 32'd1, 32'h7fffffff, 32'd1, 32'd2));
      send_item(make_item(FUNC_SUB, 32'd5, -32'sd6, 32'd7, 32'd6));

      // random items
      repeat (NumRandom) begin
         f = func_type'($urandom_range(0, 3));
         send_item(make_item(f, pick_value(), pick_den(), pick_value(), pick_den()));
      end
      start <= 1'b0;
      req   <= '0;

      // drain, then a short quiet period
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("rational_arith_unit_test: done, clean");
      else
         $display("rational_arith_unit_test: done, errors");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+src
src/rau_pkg.sv
src/rau_front.sv
src/rau_queue.sv
src/rau_divider.sv
src/rau_back.sv
src/rational_arith_unit.sv
tb/sv/rational_arith_unit_test.sv
